[src/blr_pkg.sv]
// shared types and constants for the bresenham line rasterizer
`default_nettype none

package blr_pkg;

  localparam int unsigned SCREEN_WIDTH = 240;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_code_t;

  typedef struct packed {
    cmd_code_t   command;
    logic [7:0]  start_x;
    logic [7:0]  start_y;
    logic [7:0]  end_x;
    logic [7:0]  end_y;
    logic [14:0] line_colour;
  } cmd_t;

  typedef struct packed {
    logic [15:0] pixel_address;
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic [14:0] pixel_colour;
    logic        last_pixel;
  } pix_t;

  // line parameters worked out from the two endpoints
  typedef struct packed {
    logic [7:0] long_span;
    logic [7:0] short_span;
    logic [1:0] diag_step_x;
    logic [1:0] diag_step_y;
    logic [1:0] major_step_x;
    logic [1:0] major_step_y;
  } setup_t;

  function automatic logic [15:0] pixel_addr(input logic [7:0] x, input logic [7:0] y);
    logic [15:0] prod;
    prod = 16'(y) * 16'(SCREEN_WIDTH);
    return prod + 16'(x);
  endfunction

endpackage

`default_nettype wire

[src/blr_setup.sv]
// endpoint setup: step directions and major/minor spans of a new line
`default_nettype none

module blr_setup (
  input  wire logic [7:0]     x0,
  input  wire logic [7:0]     y0,
  input  wire logic [7:0]     x1,
  input  wire logic [7:0]     y1,
  output blr_pkg::setup_t     setup
);
  import blr_pkg::*;

  logic [8:0] dw;
  logic [8:0] dh;
  logic [7:0] aw;
  logic [7:0] ah;
  logic [1:0] sx;
  logic [1:0] sy;

  always_comb begin
    dw = {1'b0, x1} - {1'b0, x0};
    dh = {1'b0, y1} - {1'b0, y0};
    aw = dw[8] ? 8'(-dw) : dw[7:0];
    ah = dh[8] ? 8'(-dh) : dh[7:0];
    // two's complement -1 / 0 / +1
    sx = dw[8] ? 2'b11 : ((dw == 9'd0) ? 2'b00 : 2'b01);
    sy = dh[8] ? 2'b11 : ((dh == 9'd0) ? 2'b00 : 2'b01);

    setup.diag_step_x = sx;
    setup.diag_step_y = sy;
    if (ah > aw) begin
      setup.long_span    = ah;
      setup.short_span   = aw;
      setup.major_step_x = 2'b00;
      setup.major_step_y = sy;
    end else begin
      setup.long_span    = aw;
      setup.short_span   = ah;
      setup.major_step_x = sx;
      setup.major_step_y = 2'b00;
    end
  end

endmodule

`default_nettype wire

[src/blr_engine.sv]
// line state and the per-pixel error step
`default_nettype none

module blr_engine (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         go,
  input  wire blr_pkg::cmd_t item,
  output logic              res_valid,
  output blr_pkg::pix_t     res
);
  import blr_pkg::*;

  logic        busy;
  logic [7:0]  cur_x;
  logic [7:0]  cur_y;
  logic [8:0]  error_term;
  logic [7:0]  long_span;
  logic [7:0]  short_span;
  logic [7:0]  pixels_left;
  logic [1:0]  diag_step_x;
  logic [1:0]  diag_step_y;
  logic [1:0]  major_step_x;
  logic [1:0]  major_step_y;
  logic [14:0] held_colour;

  setup_t      setup;
  logic [8:0]  err_sum;
  logic        diag;
  logic [8:0]  error_next;
  logic [7:0]  x_next;
  logic [7:0]  y_next;
  logic        last;

  blr_setup u_setup (
    .x0    (item.start_x),
    .y0    (item.start_y),
    .x1    (item.end_x),
    .y1    (item.end_y),
    .setup (setup)
  );

  always_comb begin
    last       = (pixels_left == 8'd0);
    err_sum    = error_term + {1'b0, short_span};
    diag       = err_sum > {1'b0, long_span};
    error_next = diag ? (err_sum - {1'b0, long_span}) : err_sum;
    if (diag) begin
      x_next = cur_x + {{6{diag_step_x[1]}}, diag_step_x};
      y_next = cur_y + {{6{diag_step_y[1]}}, diag_step_y};
    end else begin
      x_next = cur_x + {{6{major_step_x[1]}}, major_step_x};
      y_next = cur_y + {{6{major_step_y[1]}}, major_step_y};
    end

    res_valid         = (item.command == CMD_STEP) && busy;
    res.pixel_address = pixel_addr(cur_x, cur_y);
    res.pixel_x       = cur_x;
    res.pixel_y       = cur_y;
    res.pixel_colour  = held_colour;
    res.last_pixel    = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (go) begin
      if (item.command == CMD_START) begin
        busy <= 1'b1;
      end else if (busy && last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      if (item.command == CMD_START) begin
        cur_x        <= item.start_x;
        cur_y        <= item.start_y;
        error_term   <= {2'b00, setup.long_span[7:1]};
        long_span    <= setup.long_span;
        short_span   <= setup.short_span;
        pixels_left  <= setup.long_span;
        diag_step_x  <= setup.diag_step_x;
        diag_step_y  <= setup.diag_step_y;
        major_step_x <= setup.major_step_x;
        major_step_y <= setup.major_step_y;
        held_colour  <= item.line_colour;
      end else if (busy) begin
        cur_x      <= x_next;
        cur_y      <= y_next;
        error_term <= error_next;
        if (!last) begin
          pixels_left <= pixels_left - 8'd1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[src/bresenham_line_rasterizer_core.sv]
// top level of the bresenham line rasterizer
//
// cmd channel: a start item (command = start) loads both endpoints and the
// colour and produces no pixel; a step item (command = step) produces the next
// pixel of the running line, in order from the first endpoint to the second.
// a step while no line runs produces nothing; a start always restarts.
// pix channel: one item per pixel with frame buffer address, x, y, colour and
// last_pixel on pixel long_span+1, after which the line is finished.
// a step item passes the input register and then the result register on its way
// to pix (one input register, one result register).
// throughput: one item per cycle while the receiver takes each pixel; the error update is one add, one compare and
// one subtract, and the address one constant multiply and add.
// when the receiver stalls the pixel holds in the result register, one more
// item that would produce a pixel waits in the input register, and cmd_ready then drops.
// reset marks the input and result registers empty and ends any running line.
`default_nettype none

module bresenham_line_rasterizer_core (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cmd_valid,
  output logic              cmd_ready,
  input  wire blr_pkg::cmd_t cmd,
  output logic              pix_valid,
  input  wire logic         pix_ready,
  output blr_pkg::pix_t     pix
);
  import blr_pkg::*;

  logic  in_full;
  cmd_t  in_q;
  logic  res_valid;
  pix_t  res;
  logic  out_free;
  logic  advance;

  blr_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .go        (advance),
    .item      (in_q),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_free  = !pix_valid || pix_ready;
  // items that produce no pixel never wait on the output side
  assign advance   = in_full && (!res_valid || out_free);
  assign cmd_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (cmd_ready) begin
      in_full <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_ready && cmd_valid) begin
      in_q <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (advance && res_valid) begin
      pix_valid <= 1'b1;
    end else if (pix_ready) begin
      pix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      pix <= res;
    end
  end

endmodule

`default_nettype wire

[src/blr_checker.sv]
// port-level checks for the bresenham line rasterizer and their bind
`default_nettype none

module blr_checker (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cmd_valid,
  input  wire logic         cmd_ready,
  input  wire blr_pkg::cmd_t cmd,
  input  wire logic         pix_valid,
  input  wire logic         pix_ready,
  input  wire blr_pkg::pix_t pix
);
  import blr_pkg::*;

  // nothing on the output right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !pix_valid)
    else $error("pixel valid after reset");

  // a stalled pixel holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix_ready |=> pix_valid && $stable(pix))
    else $error("pixel changed while stalled");

  // address always agrees with the coordinates
  a_addr: assert property (@(posedge clk) disable iff (rst)
    pix_valid |-> pix.pixel_address == pixel_addr(pix.pixel_x, pix.pixel_y))
    else $error("pixel address does not match x and y");

  // an empty result register never blocks the command side
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !pix_valid |-> cmd_ready)
    else $error("command stalled with no pending pixel");

endmodule

bind bresenham_line_rasterizer_core blr_checker u_blr_checker (.*);

`default_nettype wire
